>>> hdl/assert_macros.svh
// assertion macros shared by the encoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define B64E_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen outside reset
`define B64E_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> hdl/b64e_pkg.sv
// types, constants and character functions for the base64 stream encoder
package b64e_pkg;

    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } t_phase;

    // one classified input item: up to two sextets and up to two escaped pads
    typedef struct packed {
        logic [5:0] sx0;
        logic [5:0] sx1;
        logic       two_sx;
        logic [1:0] pads;
        logic       eom;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    localparam logic [7:0] PAD_PERCENT = 8'h25;
    localparam logic [7:0] PAD_THREE   = 8'h33;
    localparam logic [7:0] PAD_D       = 8'h44;

    // standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // k counts characters within the pad run, three per pad
    function automatic logic [7:0] pad_char(input logic [2:0] k);
        logic [7:0] c;
        case (k) inside
            3'd0, 3'd3: c = PAD_PERCENT;
            3'd1, 3'd4: c = PAD_THREE;
            default:    c = PAD_D;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/b64e_byte_if.sv
// input channel: one raw byte and its end of message flag per item
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source(output valid, output data_byte, output end_of_message, input ready);
    modport sink(input valid, input data_byte, input end_of_message, output ready);
endinterface

>>> hdl/b64e_char_if.sv
// output channel: one encoded character and its last flag per item
interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source(output valid, output out_char, output last_char, input ready);
    modport sink(input valid, input out_char, input last_char, output ready);
endinterface

>>> hdl/b64e_queue.sv
// short job queue between the classifier and the character sequencer
`include "assert_macros.svh"

module b64e_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  b64e_pkg::t_job      i_job,
    input  logic                i_pop,
    output b64e_pkg::t_job      o_head,
    output b64e_pkg::t_q_status o_status
);
    import b64e_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_head         = r_mem[r_rd];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CW'(DEPTH));

    `B64E_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "queue overfilled")
    `B64E_ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && (r_count == '0), "pop of empty queue")

endmodule

>>> hdl/b64e_front.sv
// front part: accepts bytes, tracks the group phase and classifies each item
module b64e_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    b64e_byte_if.sink           i_byte,
    input  b64e_pkg::t_q_status i_q_status,
    output logic                o_push,
    output b64e_pkg::t_job      o_job
);
    import b64e_pkg::*;

    t_phase     r_phase, n_phase;
    logic [3:0] r_left, n_left;
    logic [7:0] b;

    assign b            = i_byte.data_byte;
    assign i_byte.ready = !i_q_status.full;
    assign o_push       = i_byte.valid && !i_q_status.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_0;
            r_left  <= '0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    always_comb begin
        o_job = '0;
        unique case (r_phase)
            PH_1: begin
                o_job.sx0 = {r_left[1:0], b[7:4]};
                n_left    = b[3:0];
                n_phase   = PH_2;
            end
            PH_2: begin
                o_job.sx0    = {r_left, b[7:6]};
                o_job.sx1    = b[5:0];
                o_job.two_sx = 1'b1;
                n_left       = '0;
                n_phase      = PH_0;
            end
            default: begin
                o_job.sx0 = b[7:2];
                n_left    = {2'b00, b[1:0]};
                n_phase   = PH_1;
            end
        endcase

        // flush the partial sextet and pick the pad count
        o_job.eom = i_byte.end_of_message;
        if (i_byte.end_of_message) begin
            if (n_phase == PH_1) begin
                o_job.sx1    = {n_left[1:0], 4'b0000};
                o_job.two_sx = 1'b1;
                o_job.pads   = 2'd2;
            end else if (n_phase == PH_2) begin
                o_job.sx1    = {n_left, 2'b00};
                o_job.two_sx = 1'b1;
                o_job.pads   = 2'd1;
            end
            n_phase = PH_0;
            n_left  = '0;
        end
    end

endmodule

>>> hdl/b64e_back.sv
// back part: walks each job out as characters through the output register
`include "assert_macros.svh"

module b64e_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  b64e_pkg::t_job      i_head,
    input  b64e_pkg::t_q_status i_q_status,
    output logic                o_pop,
    b64e_char_if.source         o_char
);
    import b64e_pkg::*;

    logic [2:0] r_pos, n_pos;
    logic       r_valid, n_valid;
    logic [7:0] r_out, n_out;
    logic       r_last, n_last;

    logic [2:0] pad_span;
    logic [2:0] last_idx;
    logic [2:0] pad_k;
    logic       take;
    logic       at_end;

    always_comb begin
        case (i_head.pads)
            2'd2:    pad_span = 3'd6;
            2'd1:    pad_span = 3'd3;
            default: pad_span = 3'd0;
        endcase
    end

    assign last_idx = pad_span + {2'b00, i_head.two_sx};
    assign pad_k    = r_pos - 3'd1 - {2'b00, i_head.two_sx};
    assign take     = !i_q_status.empty && (!r_valid || o_char.ready);
    assign at_end   = (r_pos == last_idx);
    assign o_pop    = take && at_end;

    always_comb begin
        n_pos   = r_pos;
        n_valid = r_valid;
        n_out   = r_out;
        n_last  = r_last;
        if (take) begin
            if (r_pos == 3'd0) begin
                n_out = sextet_char(i_head.sx0);
            end else if (r_pos == 3'd1 && i_head.two_sx) begin
                n_out = sextet_char(i_head.sx1);
            end else begin
                n_out = pad_char(pad_k);
            end
            n_last  = i_head.eom && at_end;
            n_valid = 1'b1;
            n_pos   = at_end ? 3'd0 : r_pos + 3'd1;
        end else if (o_char.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_last <= n_last;
    end

    assign o_char.valid     = r_valid;
    assign o_char.out_char  = r_out;
    assign o_char.last_char = r_last;

    `B64E_ASSERT(a_pos_in_job, i_clk, i_rst_n, i_q_status.empty || (r_pos <= last_idx), "character position past end of job")

endmodule

>>> hdl/base64_stream_encoder_core.sv
// base64 stream encoder: one byte per item in, one character per item out, escaped padding
// path: an accepted byte enters the job queue; its characters leave via the output register
// throughput: one byte per cycle accepted while the job queue has room; one character per
// cycle out while a job is queued and the receiver is ready, set by the single output
// register; three bytes give four characters, a final byte with padding up to eight
// reset: synchronous, active low; clears group phase, job queue and output valid
module base64_stream_encoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64e_byte_if.sink   i_byte,
    b64e_char_if.source o_char
);
    import b64e_pkg::*;

    t_job      push_job;
    t_job      head_job;
    t_q_status q_status;
    logic      push;
    logic      pop;

    b64e_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (i_byte),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (q_status)
    );

    b64e_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_job),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_char     (o_char)
    );

endmodule
